### hdl/tkdp_pkg.sv
// Package with the payload types and fixed field widths of the top-k port selector.
`default_nettype none

package tkdp_pkg;

  localparam int unsigned BytesW  = 32;
  localparam int unsigned PortW   = 16;
  localparam int unsigned RankW   = 4;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned TopCntW = 5;

  localparam logic [TopCntW-1:0] TopCountRst = 5'd10;

  typedef struct packed {
    logic [BytesW-1:0] byte_count;
    logic [PortW-1:0]  source_port;
    logic              final_record;
  } in_item_t;

  typedef struct packed {
    logic [RankW-1:0]  rank;
    logic [PortW-1:0]  chosen_port;
    logic [BytesW-1:0] chosen_bytes;
    logic [IndexW-1:0] entry_index;
    logic              found;
    logic              run_end;
  } out_item_t;

  // One entry of the flow table.
  typedef struct packed {
    logic [PortW-1:0]  port;
    logic [BytesW-1:0] bytes;
  } entry_t;

endpackage

`default_nettype wire

### hdl/top_k_distinct_port_select_top.sv
// Top level of the top-k distinct-port selector: configuration, table and result register.
`default_nettype none

// Flow records are loaded into the table at one per cycle until a record
// marked final_record arrives; records beyond MaxEntries are dropped. The
// selection run then makes one pick per full scan of the table through its
// single read port: each scan reads every loaded entry, drains the read
// pipeline and ends in a decide step, where a result waits while the output
// register cannot take it. A scan yields either a result or the discard of
// a duplicate-port entry, which is zeroed in the table before the next scan.
// During a run no record is taken; the next load starts when the last
// result of the run has moved into the output register. top_count is 0 to
// 31, with 0 read as 1 and values above MaxTop read as MaxTop, and should
// be written only while no run is in progress.
module top_k_distinct_port_select_top #(
  parameter int unsigned MaxEntries = 256,
  parameter int unsigned MaxTop     = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire tkdp_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output tkdp_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tkdp_pkg::TopCntW-1:0]  cfg_data_i
);
  import tkdp_pkg::*;

  localparam int unsigned AddrW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  logic [TopCntW-1:0] top_count_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic              res_ready;
  logic              res_valid;
  out_item_t         res;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  entry_t            wr_data;
  logic [AddrW-1:0]  rd_addr;
  entry_t            rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TopCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      top_count_q <= cfg_data_i;
    end
  end

  tkdp_store #(
    .Depth (MaxEntries),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  tkdp_select #(
    .MaxEntries (MaxEntries),
    .MaxTop     (MaxTop),
    .AddrW      (AddrW)
  ) u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .top_count_i (top_count_q),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  // The output register takes a new result when it is empty or its current
  // result is transferred in the same cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_ready)
    else $error("result issued while the output register holds an untaken result");

  a_empty_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |->
      (out_data_o.run_end && (out_data_o.chosen_bytes == '0)))
    else $error("result without a candidate must end the run with zero bytes");

  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> (out_data_o.chosen_bytes != '0))
    else $error("chosen entry carries a zero byte count");

  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res.run_end) |=> in_stall_o)
    else $error("input taken in the middle of a selection run");

endmodule

`default_nettype wire

### hdl/tkdp_store.sv
// Flow table memory: one write port and one read port with registered read data.
`default_nettype none

module tkdp_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AddrW-1:0]     wr_addr_i,
  input  wire tkdp_pkg::entry_t     wr_data_i,
  input  wire logic [AddrW-1:0]     rd_addr_i,
  output tkdp_pkg::entry_t          rd_data_o
);
  import tkdp_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/tkdp_select.sv
// Load and selection sequencer: fills the flow table, then scans it once per pick.
`default_nettype none

module tkdp_select #(
  parameter int unsigned MaxEntries = 256,
  parameter int unsigned MaxTop     = 16,
  parameter int unsigned AddrW      = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire tkdp_pkg::in_item_t              in_data_i,
  output logic                                 in_stall_o,
  input  wire logic [tkdp_pkg::TopCntW-1:0]    top_count_i,
  input  wire logic                            res_ready_i,
  output logic                                 res_valid_o,
  output tkdp_pkg::out_item_t                  res_o,
  output logic                                 wr_en_o,
  output logic [AddrW-1:0]                     wr_addr_o,
  output tkdp_pkg::entry_t                     wr_data_o,
  output logic [AddrW-1:0]                     rd_addr_o,
  input  wire tkdp_pkg::entry_t                rd_data_i
);
  import tkdp_pkg::*;

  localparam int unsigned TotW = $clog2(MaxEntries + 1);
  localparam int unsigned NW   = $clog2(MaxTop + 1);
  localparam int unsigned CW   = (MaxTop > 1) ? $clog2(MaxTop) : 1;

  typedef enum logic [1:0] {
    StLoad,
    StScan,
    StDecide
  } state_e;

  state_e            state_q;
  logic [TotW-1:0]   total_q;
  logic [TotW-1:0]   scan_q;
  logic              rd_vld_q;
  logic [AddrW-1:0]  rd_idx_q;
  logic [BytesW-1:0] best_bytes_q;
  logic [PortW-1:0]  best_port_q;
  logic [AddrW-1:0]  best_idx_q;
  logic [NW-1:0]     n_q;
  logic [PortW-1:0]  chosen_q [MaxTop];

  logic          in_acc;
  logic          full;
  logic [NW-1:0] want;
  logic          taken;
  logic          none_left;
  logic          last_rank;
  logic          scan_more;

  assign in_acc    = in_valid_i && (state_q == StLoad);
  assign full      = (total_q == TotW'(MaxEntries));
  assign none_left = (best_bytes_q == '0);
  assign last_rank = ((n_q + NW'(1)) == want);
  assign scan_more = (scan_q < total_q);

  always_comb begin
    if (top_count_i == '0) begin
      want = NW'(1);
    end else if (32'(top_count_i) > MaxTop) begin
      want = NW'(MaxTop);
    end else begin
      want = NW'(top_count_i);
    end
  end

  // Only the ports chosen so far in this run take part in the check.
  always_comb begin
    taken = 1'b0;
    for (int i = 0; i < MaxTop; i++) begin
      if ((NW'(i) < n_q) && (chosen_q[i] == best_port_q)) begin
        taken = 1'b1;
      end
    end
  end

  assign in_stall_o  = (state_q != StLoad);
  assign res_valid_o = (state_q == StDecide) && res_ready_i && (none_left || !taken);

  always_comb begin
    res_o.rank         = RankW'(n_q);
    res_o.chosen_port  = none_left ? '0 : best_port_q;
    res_o.chosen_bytes = best_bytes_q;
    res_o.entry_index  = none_left ? '0 : IndexW'(best_idx_q);
    res_o.found        = !none_left;
    res_o.run_end      = none_left || last_rank;
  end

  // Table writes happen while loading and, for the zeroing of a pick, in the
  // decide cycle. Neither overlaps a scan read, so no forwarding is needed.
  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = total_q[AddrW-1:0];
    wr_data_o = '{port: in_data_i.source_port, bytes: in_data_i.byte_count};
    if (state_q == StLoad) begin
      wr_en_o = in_acc && !full;
    end else if (state_q == StDecide) begin
      wr_addr_o = best_idx_q;
      wr_data_o = '{port: best_port_q, bytes: '0};
      wr_en_o   = !none_left && (taken || res_ready_i);
    end
  end

  assign rd_addr_o = scan_q[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StLoad;
      total_q      <= '0;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      best_bytes_q <= '0;
      best_port_q  <= '0;
      best_idx_q   <= '0;
      n_q          <= '0;
      for (int i = 0; i < MaxTop; i++) begin
        chosen_q[i] <= '0;
      end
    end else begin
      case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (!full) begin
              total_q <= total_q + TotW'(1);
            end
            if (in_data_i.final_record) begin
              state_q      <= StScan;
              scan_q       <= '0;
              best_bytes_q <= '0;
              n_q          <= '0;
            end
          end
        end
        StScan: begin
          rd_vld_q <= scan_more;
          if (scan_more) begin
            scan_q   <= scan_q + TotW'(1);
            rd_idx_q <= scan_q[AddrW-1:0];
          end
          // Strictly greater keeps the earliest entry on a tie.
          if (rd_vld_q && (rd_data_i.bytes > best_bytes_q)) begin
            best_bytes_q <= rd_data_i.bytes;
            best_port_q  <= rd_data_i.port;
            best_idx_q   <= rd_idx_q;
          end
          if (!scan_more && !rd_vld_q) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          if (none_left) begin
            if (res_ready_i) begin
              total_q <= '0;
              state_q <= StLoad;
            end
          end else if (taken) begin
            scan_q       <= '0;
            best_bytes_q <= '0;
            state_q      <= StScan;
          end else if (res_ready_i) begin
            chosen_q[n_q[CW-1:0]] <= best_port_q;
            n_q                   <= n_q + NW'(1);
            if (last_rank) begin
              total_q <= '0;
              state_q <= StLoad;
            end else begin
              scan_q       <= '0;
              best_bytes_q <= '0;
              state_q      <= StScan;
            end
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### bench/top_port_checker.sv
// Checker that predicts the top-k port selector's results from observed transfers and compares.
module top_port_checker #(
  parameter int unsigned MaxEntries = 256,
  parameter int unsigned MaxTop     = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  tkdp_pkg::in_item_t           in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  tkdp_pkg::out_item_t          out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [tkdp_pkg::TopCntW-1:0] cfg_data_i,
  output int unsigned                  pending_o,
  output int unsigned                  mismatches_o
);
  import tkdp_pkg::*;

  logic [BytesW-1:0]  flow_bytes [MaxEntries];
  logic [PortW-1:0]   flow_port  [MaxEntries];
  int unsigned        flow_fill;
  logic [PortW-1:0]   picked_port [MaxTop];
  logic [TopCntW-1:0] top_setting;
  out_item_t          expected_picks [$];
  out_item_t          want_pick;
  int unsigned        mismatch_total;

  // Runs one selection over the loaded table and queues the results it should give.
  task automatic predict_top_ports();
    int unsigned       want;
    int unsigned       n;
    int                best_at;
    logic [BytesW-1:0] best;
    logic              port_seen;
    out_item_t         pick;
    want = (top_setting == '0) ? 1 : ((top_setting > MaxTop) ? MaxTop : top_setting);
    n = 0;
    while (n < want) begin
      best = '0;
      best_at = -1;
      for (int i = 0; i < flow_fill; i++) begin
        if (flow_bytes[i] > best) begin
          best = flow_bytes[i];
          best_at = i;
        end
      end
      pick = '0;
      pick.rank = n[RankW-1:0];
      if (best_at < 0) begin
        // Nothing nonzero is left, so the run closes with an empty rank.
        pick.run_end = 1'b1;
        expected_picks.push_back(pick);
        break;
      end
      port_seen = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (picked_port[j] == flow_port[best_at]) port_seen = 1'b1;
      end
      flow_bytes[best_at] = '0;
      if (!port_seen) begin
        picked_port[n]    = flow_port[best_at];
        pick.chosen_port  = flow_port[best_at];
        pick.chosen_bytes = best;
        pick.entry_index  = best_at[IndexW-1:0];
        pick.found        = 1'b1;
        pick.run_end      = (n + 1 == want);
        expected_picks.push_back(pick);
        n++;
      end
    end
    flow_fill = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_fill      = 0;
      top_setting    = TopCountRst;
      mismatch_total = 0;
      expected_picks.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) top_setting = cfg_data_i;

      if (out_valid_i && !out_stall_i) begin
        if (expected_picks.size() == 0) begin
          mismatch_total++;
          $display("%0t: result transfer with nothing expected, got %h", $time, out_data_i);
        end else begin
          want_pick = expected_picks.pop_front();
          if (out_data_i.rank !== want_pick.rank ||
              out_data_i.chosen_port !== want_pick.chosen_port ||
              out_data_i.chosen_bytes !== want_pick.chosen_bytes ||
              out_data_i.entry_index !== want_pick.entry_index ||
              out_data_i.found !== want_pick.found ||
              out_data_i.run_end !== want_pick.run_end) begin
            mismatch_total++;
            $display({"%0t: mismatch, expected rank %0d port %h bytes %h index %0d",
                      " found %b end %b, got rank %0d port %h bytes %h index %0d",
                      " found %b end %b"},
                     $time, want_pick.rank, want_pick.chosen_port, want_pick.chosen_bytes,
                     want_pick.entry_index, want_pick.found, want_pick.run_end,
                     out_data_i.rank, out_data_i.chosen_port, out_data_i.chosen_bytes,
                     out_data_i.entry_index, out_data_i.found, out_data_i.run_end);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        // Records that arrive with the table full are dropped.
        if (flow_fill < MaxEntries) begin
          flow_bytes[flow_fill] = in_data_i.byte_count;
          flow_port[flow_fill]  = in_data_i.source_port;
          flow_fill++;
        end
        if (in_data_i.final_record) predict_top_ports();
      end

      pending_o    <= expected_picks.size();
      mismatches_o <= mismatch_total;
    end
  end

endmodule

### bench/testbench.sv
// Bench top: clock, reset, record and configuration stimulus, result stalls and the verdict.
module testbench;
  import tkdp_pkg::*;

  localparam int unsigned MaxEntries = 256;
  localparam int unsigned MaxTop     = 16;
  localparam int unsigned WatchLimit = 250000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TopCntW-1:0] cfg_data  = '0;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned records_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  bit          hold_req     = 1'b0;
  bit          hold_seen    = 1'b0;
  int unsigned rx_wait      = 0;

  always #5 clk = ~clk;

  top_k_distinct_port_select_top #(
    .MaxEntries(MaxEntries),
    .MaxTop    (MaxTop)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  top_port_checker #(
    .MaxEntries(MaxEntries),
    .MaxTop    (MaxTop)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  task automatic push_record(logic [BytesW-1:0] b, logic [PortW-1:0] p, logic last);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_count: b, source_port: p, final_record: last};
    do @(posedge clk); while (in_stall);
    records_sent++;
  endtask

  // Sends one load with random content; the last record closes it.
  task automatic send_load(int unsigned count);
    logic [PortW-1:0]  base;
    logic [PortW-1:0]  p;
    logic [BytesW-1:0] b;
    bit                narrow;
    narrow  = ($urandom_range(0, 2) != 0);
    base    = PortW'($urandom);
    tx_calm = ($urandom_range(0, 4) == 0);
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0:       b = '0;
        1:       b = '1;
        default: b = narrow ? BytesW'($urandom_range(0, 12)) : BytesW'($urandom);
      endcase
      p = narrow ? base + PortW'($urandom_range(0, 3)) : PortW'($urandom);
      push_record(b, p, k == count - 1);
    end
  endtask

  // Stops sending and waits until every expected result has come and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_top_count(logic [TopCntW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls after each transfer, calm stretches, and one long hold-off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        rx_wait   = 600;
        out_stall <= 1'b1;
      end else if (out_stall) begin
        if (rx_wait <= 1) begin
          rx_wait = 0;
          out_stall <= 1'b0;
        end else begin
          rx_wait--;
        end
      end else if (out_valid) begin
        if (out_data.run_end) rx_calm = ($urandom_range(0, 3) == 0);
        rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
        if (rx_wait != 0) out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("[top_k_distinct_port_select_top] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting of ten: extremes, a tie, a repeated port and a zero count left over.
    push_record(32'hFFFF_FFFF, 16'h0000, 1'b0);
    push_record(32'd0, 16'hFFFF, 1'b0);
    push_record(32'd100, 16'd7, 1'b0);
    push_record(32'd100, 16'd9, 1'b0);
    push_record(32'd200, 16'd7, 1'b0);
    push_record(32'd50, 16'hFFFF, 1'b1);

    // A zero setting still yields one result.
    settle();
    write_top_count(5'd0);
    push_record(32'd10, 16'd1, 1'b0);
    push_record(32'd10, 16'd2, 1'b1);

    // The largest setting saturates to the top list size.
    settle();
    write_top_count(5'd31);
    push_record(32'd0, 16'h1234, 1'b1);
    for (int unsigned k = 0; k < MaxTop; k++) begin
      push_record(BytesW'(k + 1), PortW'(16'hA000 + k), k == MaxTop - 1);
    end

    phase = 0;
    while ((records_sent < 420) || (phase < 9)) begin
      phase++;
      if (phase == 4) begin
        // Overfill the table so that the final record itself is dropped.
        settle();
        write_top_count(5'd16);
        send_load(MaxEntries + 2);
      end else if (phase == 9) begin
        // The result side holds off while loads keep coming, so the input backs up.
        hold_req <= ~hold_req;
        repeat (3) send_load($urandom_range(2, 8));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          settle();
          case ($urandom_range(0, 5))
            0:       write_top_count(5'd0);
            1:       write_top_count(5'd1);
            2:       write_top_count(5'd16);
            3:       write_top_count(5'd17);
            4:       write_top_count(5'd31);
            default: write_top_count(TopCntW'($urandom_range(1, 16)));
          endcase
        end
        send_load(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12));
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[top_k_distinct_port_select_top] OK");
    end else begin
      $display("[top_k_distinct_port_select_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tkdp_pkg.sv
hdl/tkdp_store.sv
hdl/tkdp_select.sv
hdl/top_k_distinct_port_select_top.sv
bench/top_port_checker.sv
bench/testbench.sv
